>>> sv/u8u16_pkg.sv
// Shared types and constants for the UTF-8 to UTF-16 transcoder.
`default_nettype none

package u8u16_pkg;

    localparam int QUEUE_DEPTH_DEF = 4;

    localparam logic [15:0] HIGH_SURR_BASE = 16'hD800;
    localparam logic [15:0] LOW_SURR_BASE  = 16'hDC00;
    localparam logic [20:0] SUPP_BASE      = 21'h10000;
    localparam logic [20:0] CODE_MAX       = 21'h10FFFF;
    localparam logic [20:0] SURR_FIRST     = 21'h0D800;
    localparam logic [20:0] SURR_LAST      = 21'h0DFFF;
    localparam logic [20:0] TWO_BYTE_MIN   = 21'h00080;
    localparam logic [20:0] THREE_BYTE_MIN = 21'h00800;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       last_byte;
    } in_item_t;

    typedef struct packed {
        logic [15:0] code_unit;
        logic        unit_valid;
        logic        bad_input;
        logic        end_of_string;
    } out_item_t;

    typedef enum logic [1:0] {
        JOB_UNIT = 2'd0,
        JOB_PAIR = 2'd1,
        JOB_END  = 2'd2
    } job_op_t;

    // One unit, one surrogate pair (payload is the code point less 0x10000),
    // or a bare end marker.
    typedef struct packed {
        job_op_t     op;
        logic [19:0] payload;
        logic        eos;
        logic        bad;
    } job_t;

    typedef struct packed {
        logic full;
        logic head_valid;
    } q_status_t;

endpackage

`default_nettype wire

>>> sv/u8u16_front.sv
// Front end: decodes UTF-8 bytes and posts output jobs to the queue.
`default_nettype none

module u8u16_front
    import u8u16_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     take,
    input  wire in_item_t item,
    output logic          push,
    output job_t          push_job
);

    logic [1:0]  pend_reg, pend_next;
    logic [1:0]  seq_reg, seq_next;
    logic [20:0] part_reg, part_next;
    logic        err_reg, err_next;

    logic [7:0]  c;
    logic [20:0] cp_full;
    logic [20:0] cp_off;
    logic        cp_bad;
    logic        unit_go;
    logic        pair_go;

    assign c       = item.in_byte;
    assign cp_full = {part_reg[14:0], c[5:0]};
    assign cp_off  = cp_full - SUPP_BASE;

    always_comb
    begin
        unique case (seq_reg)
            2'd1:    cp_bad = cp_full < TWO_BYTE_MIN;
            2'd2:    cp_bad = (cp_full < THREE_BYTE_MIN) ||
                              ((cp_full >= SURR_FIRST) && (cp_full <= SURR_LAST));
            default: cp_bad = (cp_full < SUPP_BASE) || (cp_full > CODE_MAX);
        endcase
    end

    always_comb
    begin
        pend_next = pend_reg;
        seq_next  = seq_reg;
        part_next = part_reg;
        err_next  = err_reg;
        unit_go   = 1'b0;
        pair_go   = 1'b0;
        push      = 1'b0;
        push_job  = '0;

        if (!err_reg)
        begin
            if (pend_reg == 2'd0)
            begin
                unique case (c) inside
                    [8'h00:8'h7F]:
                    begin
                        unit_go = 1'b1;
                    end
                    [8'hC0:8'hDF]:
                    begin
                        part_next = {16'd0, c[4:0]};
                        pend_next = 2'd1;
                        seq_next  = 2'd1;
                    end
                    [8'hE0:8'hEF]:
                    begin
                        part_next = {17'd0, c[3:0]};
                        pend_next = 2'd2;
                        seq_next  = 2'd2;
                    end
                    [8'hF0:8'hF7]:
                    begin
                        part_next = {18'd0, c[2:0]};
                        pend_next = 2'd3;
                        seq_next  = 2'd3;
                    end
                    default:
                    begin
                        err_next = 1'b1;
                    end
                endcase
            end
            else if (c[7:6] != 2'b10)
            begin
                err_next  = 1'b1;
                pend_next = 2'd0;
            end
            else
            begin
                part_next = cp_full;
                pend_next = pend_reg - 2'd1;
                if (pend_reg == 2'd1)
                begin
                    // sequence complete: range and overlong checks
                    if (cp_bad)
                        err_next = 1'b1;
                    else if (cp_full[20:16] == 5'd0)
                        unit_go = 1'b1;
                    else
                        pair_go = 1'b1;
                    part_next = '0;
                    seq_next  = 2'd0;
                end
            end
        end

        // truncated sequence at end of string
        if (item.last_byte && !err_next && (pend_next != 2'd0))
            err_next = 1'b1;

        if (unit_go)
        begin
            push_job.op      = JOB_UNIT;
            push_job.payload = (pend_reg == 2'd0) ? {12'd0, c} : {4'd0, cp_full[15:0]};
            push_job.eos     = item.last_byte;
            push             = take;
        end
        else if (pair_go)
        begin
            push_job.op      = JOB_PAIR;
            push_job.payload = cp_off[19:0];
            push_job.eos     = item.last_byte;
            push             = take;
        end
        else if (item.last_byte)
        begin
            push_job.op  = JOB_END;
            push_job.eos = 1'b1;
            push_job.bad = err_next;
            push         = take;
        end

        if (item.last_byte)
        begin
            pend_next = '0;
            seq_next  = '0;
            part_next = '0;
            err_next  = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg <= '0;
            seq_reg  <= '0;
            part_reg <= '0;
            err_reg  <= 1'b0;
        end
        else if (take)
        begin
            pend_reg <= pend_next;
            seq_reg  <= seq_next;
            part_reg <= part_next;
            err_reg  <= err_next;
        end
    end

endmodule

`default_nettype wire

>>> sv/u8u16_queue.sv
// Short job queue between the decoder and the output stage.
`default_nettype none

module u8u16_queue
    import u8u16_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH_DEF
)
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic push,
    input  wire job_t push_job,
    input  wire logic pop,
    output job_t      head_job,
    output q_status_t status
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    job_t             mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push;
    logic             do_pop;

    assign status.full       = (count_reg == CNT_FULL);
    assign status.head_valid = (count_reg != '0);
    assign head_job          = mem[rd_ptr_reg];

    assign do_push = push && !status.full;
    assign do_pop  = pop && status.head_valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
        if (do_pop)
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
        if (do_push && !do_pop)
            count_next = count_reg + 1'b1;
        else if (do_pop && !do_push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            mem[wr_ptr_reg] <= push_job;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

`default_nettype wire

>>> sv/u8u16_back.sv
// Output stage: turns queued jobs into UTF-16 result transfers.
`default_nettype none

module u8u16_back
    import u8u16_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire job_t      head_job,
    input  wire q_status_t status,
    output logic           pop,
    input  wire logic      dst_stall,
    output logic           dst_valid,
    output out_item_t      dst_data
);

    logic      valid_reg, valid_next;
    out_item_t data_reg, data_next;
    logic      half_reg, half_next;
    logic      load;

    assign load      = !valid_reg || !dst_stall;
    assign dst_valid = valid_reg;
    assign dst_data  = data_reg;

    always_comb
    begin
        valid_next = valid_reg;
        data_next  = data_reg;
        half_next  = half_reg;
        pop        = 1'b0;
        if (load)
        begin
            valid_next = status.head_valid;
            data_next  = '0;
            if (status.head_valid)
            begin
                unique case (head_job.op)
                    JOB_UNIT:
                    begin
                        data_next.code_unit     = head_job.payload[15:0];
                        data_next.unit_valid    = 1'b1;
                        data_next.end_of_string = head_job.eos;
                        pop                     = 1'b1;
                    end
                    JOB_PAIR:
                    begin
                        data_next.unit_valid = 1'b1;
                        if (!half_reg)
                        begin
                            // high half first; hold the job for the low half
                            data_next.code_unit = HIGH_SURR_BASE |
                                                  {6'd0, head_job.payload[19:10]};
                            half_next           = 1'b1;
                        end
                        else
                        begin
                            data_next.code_unit     = LOW_SURR_BASE |
                                                      {6'd0, head_job.payload[9:0]};
                            data_next.end_of_string = head_job.eos;
                            half_next               = 1'b0;
                            pop                     = 1'b1;
                        end
                    end
                    default:
                    begin
                        data_next.bad_input     = head_job.bad;
                        data_next.end_of_string = 1'b1;
                        pop                     = 1'b1;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            half_reg  <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
            half_reg  <= half_next;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

endmodule

`default_nettype wire

>>> sv/utf8_to_utf16_transcoder.sv
// UTF-8 to UTF-16 transcoder top level.
// Takes one UTF-8 byte per cycle on the src channel and delivers UTF-16 code
// units on the dst channel, with a flagged end-of-string transfer that
// carries the malformed-string flag. The decoder accepts a byte every cycle
// while the job queue (QUEUE_DEPTH entries) has room; the output register
// delivers one code unit per cycle while dst_stall is low, so a supplementary
// code point occupies the output for two code units and the sustained rate
// is one byte or one output unit per cycle, whichever is fewer. Each result
// is registered in the queue and then in the output register.
`default_nettype none

module utf8_to_utf16_transcoder
    import u8u16_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
)
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      src_valid,
    output logic           src_stall,
    input  wire in_item_t  src_data,
    output logic           dst_valid,
    input  wire logic      dst_stall,
    output out_item_t      dst_data
);

    logic      take;
    logic      push;
    job_t      push_job;
    logic      pop;
    job_t      head_job;
    q_status_t q_status;

    assign src_stall = q_status.full;
    assign take      = src_valid && !src_stall;

    u8u16_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .take     (take),
        .item     (src_data),
        .push     (push),
        .push_job (push_job)
    );

    u8u16_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_job (push_job),
        .pop      (pop),
        .head_job (head_job),
        .status   (q_status)
    );

    u8u16_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .head_job  (head_job),
        .status    (q_status),
        .pop       (pop),
        .dst_stall (dst_stall),
        .dst_valid (dst_valid),
        .dst_data  (dst_data)
    );

`ifndef ASSERT_OFF
    // a malformed flag only ever rides on a bare end transfer
    a_bad_is_end: assert property (@(posedge clk) disable iff (!rst_n)
        (dst_valid && dst_data.bad_input) |->
            (dst_data.end_of_string && !dst_data.unit_valid))
        else $error("bad_input on a non-end result");

    // a high surrogate is always followed at once by its low half
    a_pair_order: assert property (@(posedge clk) disable iff (!rst_n)
        (dst_valid && !dst_stall && dst_data.unit_valid &&
         (dst_data.code_unit[15:10] == 6'b110110)) |=>
            (dst_valid && dst_data.unit_valid &&
             (dst_data.code_unit[15:10] == 6'b110111)))
        else $error("high surrogate not followed by low surrogate");

    // a queued job reaches an empty output register on the next cycle
    a_drain: assert property (@(posedge clk) disable iff (!rst_n)
        (q_status.head_valid && !dst_valid) |=> dst_valid)
        else $error("queued job not moved to output");

    // the decoder never posts a job into a full queue
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !q_status.full)
        else $error("job pushed into full queue");
`endif

endmodule

`default_nettype wire

>>> tb/utf8_to_utf16_transcoder_tb.sv
// Self-checking testbench for the UTF-8 to UTF-16 transcoder.
`default_nettype none

module utf8_to_utf16_transcoder_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import u8u16_pkg::*;

    localparam int RANDOM_BYTES = 870;
    localparam int CALM_TAIL    = 150;
    localparam int LONG_HOLD    = 200;
    localparam int CYCLE_LIMIT  = 400000;

    // Directed strings, {byte, last}: valid forms of every length, then each kind
    // of malformed string.
    localparam logic [8:0] DIRECTED [27] = '{
        {8'h00, 1'b0}, {8'h7F, 1'b0}, {8'hC2, 1'b0}, {8'h80, 1'b0},
        {8'hEF, 1'b0}, {8'hBF, 1'b0}, {8'hBF, 1'b0},
        {8'hF4, 1'b0}, {8'h8F, 1'b0}, {8'hBF, 1'b0}, {8'hBF, 1'b1},
        {8'h80, 1'b1},
        {8'hFF, 1'b1},
        {8'hC2, 1'b0}, {8'h41, 1'b0}, {8'h41, 1'b1},
        {8'hC0, 1'b0}, {8'h80, 1'b1},
        {8'hED, 1'b0}, {8'hA0, 1'b0}, {8'h80, 1'b1},
        {8'hF4, 1'b0}, {8'h90, 1'b0}, {8'h80, 1'b0}, {8'h80, 1'b1},
        {8'hE2, 1'b0}, {8'h82, 1'b1}
    };

    class utf16_scoreboard;
        logic [1:0]  bytes_left;
        logic [1:0]  seq_len;
        logic [20:0] code_point;
        logic        malformed;
        out_item_t   expected_units[$];
        int          mismatches;

        function new();
            clear();
            mismatches = 0;
        endfunction

        function void clear();
            bytes_left = 2'd0;
            seq_len    = 2'd0;
            code_point = 21'd0;
            malformed  = 1'b0;
        endfunction

        // Decode one accepted byte and queue the code units it yields.
        function void note_byte(in_item_t item);
            logic [7:0]  c;
            logic [15:0] units [2];
            logic [20:0] offset;
            logic        reject;
            out_item_t   res;
            int          count;
            int          k;
            c = item.in_byte;
            count = 0;
            if (!malformed) begin
                if (bytes_left == 2'd0) begin
                    if (c[7] == 1'b0) begin
                        units[0] = {8'h00, c};
                        count = 1;
                    end else if (c[7:5] == 3'b110) begin
                        code_point = {16'h0, c[4:0]};
                        bytes_left = 2'd1;
                        seq_len = 2'd1;
                    end else if (c[7:4] == 4'b1110) begin
                        code_point = {17'h0, c[3:0]};
                        bytes_left = 2'd2;
                        seq_len = 2'd2;
                    end else if (c[7:3] == 5'b11110) begin
                        code_point = {18'h0, c[2:0]};
                        bytes_left = 2'd3;
                        seq_len = 2'd3;
                    end else begin
                        malformed = 1'b1;
                    end
                end else if (c[7:6] != 2'b10) begin
                    malformed = 1'b1;
                    bytes_left = 2'd0;
                end else begin
                    code_point = {code_point[14:0], c[5:0]};
                    bytes_left = bytes_left - 2'd1;
                    if (bytes_left == 2'd0) begin
                        case (seq_len)
                            2'd1:    reject = code_point < TWO_BYTE_MIN;
                            2'd2:    reject = code_point < THREE_BYTE_MIN ||
                                              (code_point >= SURR_FIRST &&
                                               code_point <= SURR_LAST);
                            default: reject = code_point < SUPP_BASE || code_point > CODE_MAX;
                        endcase
                        if (reject) begin
                            malformed = 1'b1;
                        end else if (code_point < SUPP_BASE) begin
                            units[0] = code_point[15:0];
                            count = 1;
                        end else begin
                            offset = code_point - SUPP_BASE;
                            units[0] = HIGH_SURR_BASE + {6'h0, offset[19:10]};
                            units[1] = LOW_SURR_BASE + {6'h0, offset[9:0]};
                            count = 2;
                        end
                        code_point = 21'd0;
                        seq_len = 2'd0;
                    end
                end
            end
            // a string that ends inside a sequence is truncated
            if (item.last_byte && !malformed && bytes_left != 2'd0)
                malformed = 1'b1;
            for (k = 0; k < count; k++) begin
                res.code_unit     = units[k];
                res.unit_valid    = 1'b1;
                res.bad_input     = 1'b0;
                res.end_of_string = item.last_byte && (k == count - 1);
                expected_units.insert(expected_units.size(), res);
            end
            if (item.last_byte) begin
                if (count == 0) begin
                    res.code_unit     = 16'h0000;
                    res.unit_valid    = 1'b0;
                    res.bad_input     = malformed;
                    res.end_of_string = 1'b1;
                    expected_units.insert(expected_units.size(), res);
                end
                clear();
            end
        endfunction

        function void compare_field(string field, logic [15:0] want, logic [15:0] got);
            if (got !== want) begin
                $error("%s expected %h got %h", field, want, got);
                mismatches++;
            end
        endfunction

        function void check_unit(out_item_t got);
            out_item_t want;
            if (expected_units.size() == 0) begin
                $error("unexpected transfer: code_unit %h end_of_string %b",
                       got.code_unit, got.end_of_string);
                mismatches++;
                return;
            end
            want = expected_units.pop_front();
            compare_field("code_unit", want.code_unit, got.code_unit);
            compare_field("unit_valid", 16'(want.unit_valid), 16'(got.unit_valid));
            compare_field("bad_input", 16'(want.bad_input), 16'(got.bad_input));
            compare_field("end_of_string", 16'(want.end_of_string), 16'(got.end_of_string));
        endfunction
    endclass

    logic      clk = 1'b0;
    logic      rst_n = 1'b0;
    logic      src_valid = 1'b0;
    logic      src_stall;
    in_item_t  src_data = '0;
    logic      dst_valid;
    logic      dst_stall = 1'b0;
    out_item_t dst_data;

    logic idling = 1'b1;
    logic calm = 1'b0;
    logic hold_long = 1'b0;
    int   cycles = 0;

    utf16_scoreboard board;
    logic [7:0]      text[$];

    utf8_to_utf16_transcoder u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .src_valid (src_valid),
        .src_stall (src_stall),
        .src_data  (src_data),
        .dst_valid (dst_valid),
        .dst_stall (dst_stall),
        .dst_data  (dst_data)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("FAILED: results differ");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && dst_valid && !dst_stall)
            board.check_unit(dst_data);
    end

    // Receiver: random stall bursts, and one long hold-off when asked.
    initial
    begin : sink
        forever
        begin
            @(posedge clk);
            if (hold_long)
            begin
                dst_stall <= 1'b1;
                repeat (LONG_HOLD) @(posedge clk);
                hold_long = 1'b0;
                dst_stall <= 1'b0;
            end
            else if (idling && $urandom_range(0, 9) == 0)
            begin
                dst_stall <= 1'b1;
                repeat ($urandom_range(1, 19)) @(posedge clk);
                dst_stall <= 1'b0;
            end
        end
    end

    // Offer one byte, at times after a random idle gap, and hold it until the transfer; valid stays high afterwards.
    task automatic send_byte(input in_item_t item);
        if (idling && !calm && $urandom_range(0, 5) == 0)
        begin
            src_valid <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge clk);
        end
        src_valid <= 1'b1;
        src_data  <= item;
        @(posedge clk);
        while (src_stall) @(posedge clk);
        board.note_byte(item);
    endtask

    // Stop offering and wait for every queued code unit to arrive.
    task automatic drain_units();
        src_valid <= 1'b0;
        do
            @(posedge clk);
        while (board.expected_units.size() != 0);
    endtask

    function automatic void add_byte(logic [7:0] b);
        text.insert(text.size(), b);
    endfunction

    function automatic void push_utf8(logic [20:0] cp, int len);
        case (len)
            1: add_byte({1'b0, cp[6:0]});
            2:
            begin
                add_byte({3'b110, cp[10:6]});
                add_byte({2'b10, cp[5:0]});
            end
            3:
            begin
                add_byte({4'b1110, cp[15:12]});
                add_byte({2'b10, cp[11:6]});
                add_byte({2'b10, cp[5:0]});
            end
            default:
            begin
                add_byte({5'b11110, cp[20:18]});
                add_byte({2'b10, cp[17:12]});
                add_byte({2'b10, cp[11:6]});
                add_byte({2'b10, cp[5:0]});
            end
        endcase
    endfunction

    // Mostly well-formed sequences with random content; a few broken ones.
    task automatic build_text();
        int          seqs;
        int          roll;
        int          len;
        int          cut;
        logic [20:0] cp;
        text.delete();
        seqs = $urandom_range(1, 6);
        repeat (seqs)
        begin
            roll = $urandom_range(0, 99);
            if (roll < 33)
                push_utf8(21'($urandom_range(0, 32'h7F)), 1);
            else if (roll < 50)
                push_utf8(21'($urandom_range(32'h80, 32'h7FF)), 2);
            else if (roll < 68)
            begin
                cp = $urandom_range(0, 1) ? 21'($urandom_range(32'h800, 32'hD7FF))
                                          : 21'($urandom_range(32'hE000, 32'hFFFF));
                push_utf8(cp, 3);
            end
            else if (roll < 86)
                push_utf8(21'($urandom_range(32'h10000, 32'h10FFFF)), 4);
            else if (roll < 88)
            begin
                // overlong form
                len = $urandom_range(2, 4);
                cp = (len == 2) ? 21'($urandom_range(0, 32'h7F)) :
                     (len == 3) ? 21'($urandom_range(0, 32'h7FF)) :
                                  21'($urandom_range(0, 32'hFFFF));
                push_utf8(cp, len);
            end
            else if (roll < 89)
                push_utf8(21'($urandom_range(32'hD800, 32'hDFFF)), 3);
            else if (roll < 90)
                push_utf8(21'($urandom_range(32'h110000, 32'h1FFFFF)), 4);
            else if (roll < 93)
                add_byte(8'($urandom_range(0, 255)));
            else if (roll < 95)
            begin
                // drop the final continuation byte
                push_utf8(21'($urandom_range(0, 32'h1FFFFF)), $urandom_range(2, 4));
                void'(text.pop_back());
            end
            else
            begin
                // replace one continuation byte with a non-continuation byte
                len = $urandom_range(2, 4);
                push_utf8(21'($urandom_range(0, 32'h1FFFFF)), len);
                cut = $urandom_range(1, len - 1);
                text[text.size() - cut] = $urandom_range(0, 1) ?
                    8'($urandom_range(0, 32'h7F)) : 8'($urandom_range(32'hC0, 32'hFF));
            end
        end
    endtask

    initial
    begin : stimulus
        int   sent;
        logic paused;
        board = new();
        sent = 0;
        paused = 1'b0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (DIRECTED[i])
            send_byte(in_item_t'(DIRECTED[i]));
        drain_units();

        // hold the receiver off while bytes keep coming, so the input backs up
        hold_long = 1'b1;
        while (sent < RANDOM_BYTES)
        begin
            if (sent >= RANDOM_BYTES - CALM_TAIL)
                idling = 1'b0;
            calm = ($urandom_range(0, 3) == 0);
            build_text();
            foreach (text[i])
                send_byte({text[i], i == text.size() - 1});
            sent += text.size();
            if (!paused && sent >= RANDOM_BYTES / 2)
            begin
                drain_units();
                paused = 1'b1;
            end
        end
        drain_units();
        repeat (8) @(posedge clk);

        if (board.mismatches == 0 && board.expected_units.size() == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule

`default_nettype wire

>>> utf8_to_utf16_transcoder.f
sv/u8u16_pkg.sv
sv/u8u16_front.sv
sv/u8u16_queue.sv
sv/u8u16_back.sv
sv/utf8_to_utf16_transcoder.sv
tb/utf8_to_utf16_transcoder_tb.sv
